@@ rtl/core/pfa_pkg.sv @@
// shared types and constants of the page frame allocator
// no dependencies; used by pfa_ctrl, pfa_datapath and page_frame_allocator_core
`default_nettype none

package pfa_pkg;

  // free list and page geometry
  localparam int unsigned FreeDepth   = 1024;
  localparam int unsigned PageBytes   = 4096;
  localparam int unsigned HeaderBytes = 20;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned IdxW   = $clog2(FreeDepth);
  localparam int unsigned CountW = $clog2(FreeDepth + 1);

  localparam logic [IdxW-1:0]   IdxLast    = IdxW'(FreeDepth - 1);
  localparam logic [CountW-1:0] CountFull  = CountW'(FreeDepth);
  localparam logic [AddrW:0]    PageInc    = (AddrW + 1)'(PageBytes);
  localparam logic [AddrW-1:0]  HeaderOffs = AddrW'(HeaderBytes);

  // apb register map
  localparam int unsigned PaddrW = 3;
  localparam logic        RegRegionStart = 1'b0;
  localparam logic        RegRegionEnd   = 1'b1;

  // request kinds
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StNoMem = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef enum logic {
    FsmIdle = 1'b0,
    FsmExec = 1'b1
  } fsm_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the accepted item and read the list head
    logic exec;  // resolve the item and load the result register
  } pfa_cmd_t;

  // configuration writes toward the datapath
  typedef struct packed {
    logic             wr_start;
    logic             wr_end;
    logic [AddrW-1:0] wdata;
  } pfa_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/pfa_ctrl.sv @@
// controller state machine of the page frame allocator
// depends on pfa_pkg
`default_nettype none

module pfa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pfa_pkg::pfa_cmd_t      cmd_o
);

  pfa_pkg::fsm_e state_q, state_d;
  logic          out_valid_q, out_valid_d;
  logic          exec_go;

  assign exec_go = (state_q == pfa_pkg::FsmExec) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfa_pkg::FsmIdle: begin
        if (in_valid_i) state_d = pfa_pkg::FsmExec;
      end
      pfa_pkg::FsmExec: begin
        if (exec_go) state_d = pfa_pkg::FsmIdle;
      end
      default: state_d = pfa_pkg::FsmIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = (state_q == pfa_pkg::FsmIdle);
    cmd_o.load = in_valid_i && (state_q == pfa_pkg::FsmIdle);
    cmd_o.exec = exec_go;
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfa_pkg::FsmIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pfa_datapath.sv @@
// datapath of the page frame allocator: region registers, bump pointer,
// free list memory with head, tail and count, result register; depends on pfa_pkg
`default_nettype none

module pfa_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pfa_pkg::pfa_cmd_t          cmd_i,
  input  wire pfa_pkg::pfa_cfg_t          cfg_i,
  input  wire logic                       op_i,
  input  wire logic [pfa_pkg::AddrW-1:0]  page_address_i,
  output logic [pfa_pkg::AddrW-1:0]       region_start_o,
  output logic [pfa_pkg::AddrW-1:0]       region_end_o,
  output logic [1:0]                      status_o,
  output logic [pfa_pkg::AddrW-1:0]       granted_address_o
);

  logic [pfa_pkg::AddrW-1:0]  region_start_q, region_end_q;
  logic [pfa_pkg::AddrW-1:0]  bump_q, bump_d;
  logic [pfa_pkg::IdxW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [pfa_pkg::CountW-1:0] count_q, count_d;

  logic                       op_q;
  logic [pfa_pkg::AddrW-1:0]  addr_q;
  logic [pfa_pkg::AddrW-1:0]  rd_q;

  pfa_pkg::status_e           status_q, status_d;
  logic [pfa_pkg::AddrW-1:0]  granted_q, granted_d;

  logic [pfa_pkg::AddrW-1:0]  mem [pfa_pkg::FreeDepth];
  logic                       push;
  logic [pfa_pkg::AddrW:0]    bump_limit;

  assign bump_limit = {1'b0, bump_q} + pfa_pkg::PageInc;

  always_comb begin
    bump_d    = bump_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    status_d  = pfa_pkg::StOk;
    granted_d = '0;
    push      = 1'b0;
    if (op_q == pfa_pkg::OpAlloc) begin
      if (count_q != '0) begin
        granted_d = rd_q;
        head_d    = (head_q == pfa_pkg::IdxLast) ? '0 : head_q + 1'b1;
        count_d   = count_q - 1'b1;
      end else if (bump_limit > {1'b0, region_end_q}) begin
        status_d = pfa_pkg::StNoMem;
      end else begin
        granted_d = bump_q;
        bump_d    = bump_limit[pfa_pkg::AddrW-1:0];
      end
    end else begin
      if (count_q >= pfa_pkg::CountFull) begin
        status_d = pfa_pkg::StFull;
      end else begin
        push    = 1'b1;
        tail_d  = (tail_q == pfa_pkg::IdxLast) ? '0 : tail_q + 1'b1;
        count_d = count_q + 1'b1;
      end
    end
  end

  // control state; a region_start write restarts the allocator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= '0;
      region_end_q   <= '0;
      bump_q         <= pfa_pkg::HeaderOffs;
      head_q         <= '0;
      tail_q         <= '0;
      count_q        <= '0;
    end else begin
      if (cfg_i.wr_end) region_end_q <= cfg_i.wdata;
      if (cfg_i.wr_start) begin
        region_start_q <= cfg_i.wdata;
        bump_q         <= cfg_i.wdata + pfa_pkg::HeaderOffs;
        head_q         <= '0;
        tail_q         <= '0;
        count_q        <= '0;
      end else if (cmd_i.exec) begin
        bump_q  <= bump_d;
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
    end
  end

  // item capture and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      addr_q <= page_address_i;
    end
    if (cmd_i.exec) begin
      status_q  <= status_d;
      granted_q <= granted_d;
    end
  end

  // free list memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push) mem[tail_q] <= addr_q;
    if (cmd_i.load) rd_q <= mem[head_q];
  end

  assign region_start_o    = region_start_q;
  assign region_end_o      = region_end_q;
  assign status_o          = status_q;
  assign granted_address_o = granted_q;

endmodule

`default_nettype wire

@@ rtl/core/page_frame_allocator_core.sv @@
// top level of the page frame allocator: apb register decode and the
// controller and datapath instances; depends on pfa_pkg, pfa_ctrl, pfa_datapath
//
// usage
// - request channel (in_valid_i/in_ready_o): op_i 0 allocates a page,
//   1 frees page_address_i back to the fifo free list
// - result channel (out_valid_o/out_ready_i): one item per request,
//   status_o 0 ok, 1 out of memory, 2 free list full; granted_address_o
//   holds the page on a good allocate, zero otherwise
// - per item, the accept edge reads the free list head from
//   its memory port; the resolve step then writes the result register
// - a new item is taken while the previous result still waits; if the
//   receiver stalls, the next item holds in the resolve step until the
//   result register is taken, and no further item is accepted
// - apb: region_start at 0x0, region_end at 0x4; writing region_start
//   empties the free list and restarts the bump pointer 20 bytes above it
// - reset: region registers zero, bump pointer 20, free list empty, no
//   result pending; the free list memory itself is not cleared
`default_nettype none

module page_frame_allocator_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        op_i,
  input  wire logic [pfa_pkg::AddrW-1:0]   page_address_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       status_o,
  output logic [pfa_pkg::AddrW-1:0]        granted_address_o,
  // apb configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pfa_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  pfa_pkg::pfa_cmd_t          cmd;
  pfa_pkg::pfa_cfg_t          cfg;
  logic                       apb_wr;
  logic [pfa_pkg::AddrW-1:0]  region_start, region_end;

  // zero wait-state apb; register selected by word address bit
  assign pready    = 1'b1;
  assign apb_wr    = psel && penable && pwrite;
  assign cfg.wr_start = apb_wr && (paddr[2] == pfa_pkg::RegRegionStart);
  assign cfg.wr_end   = apb_wr && (paddr[2] == pfa_pkg::RegRegionEnd);
  assign cfg.wdata    = pwdata;

  // read back mux
  assign prdata = (paddr[2] == pfa_pkg::RegRegionEnd) ? region_end : region_start;

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  pfa_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_i             (cfg),
    .op_i              (op_i),
    .page_address_i    (page_address_i),
    .region_start_o    (region_start),
    .region_end_o      (region_end),
    .status_o          (status_o),
    .granted_address_o (granted_address_o)
  );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// self-checking testbench for page_frame_allocator_core: a directed table, then random
// alloc/free traffic checked against an in-bench free list and bump pointer
// depends on pfa_pkg and page_frame_allocator_core
`default_nettype none

module tb_top;
  import pfa_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned NumRows    = 23;

  // one expected result item
  typedef struct packed {
    status_e          st;
    logic [AddrW-1:0] page;
  } grant_t;

  // directed rows are either a request item or a register write
  typedef enum logic [1:0] {
    RowItem  = 2'd0,
    RowWrite = 2'd1
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             op;      // request kind for item rows
    logic             sel;     // register for write rows
    logic [AddrW-1:0] data;    // page address or register value
    logic             fixed;   // expected result typed in below
    status_e          st;
    logic [AddrW-1:0] page;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                op_i;
  logic [AddrW-1:0]    page_address_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          status_o;
  logic [AddrW-1:0]    granted_address_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // in-bench copy of the allocator state
  logic [AddrW-1:0]    cfg_start;
  logic [AddrW-1:0]    cfg_end;
  logic [AddrW-1:0]    next_page;
  logic [AddrW-1:0]    recycled [FreeDepth];
  logic [IdxW-1:0]     rd_idx;
  logic [IdxW-1:0]     wr_idx;
  logic [CountW-1:0]   free_cnt;

  grant_t              pending_grants [$];  // expected results, oldest first
  logic [AddrW-1:0]    handed_out [$];      // pages granted so far, candidates to free
  int unsigned         errors;
  int unsigned         full_hits;
  int unsigned         issued;
  int unsigned         cycles;
  bit                  quiet;               // both sides run without gaps

  // directed stimulus; the first rows run with both region registers at reset (zero)
  dir_row_t dir_rows [NumRows] = '{
    // bump region empty at reset: alloc is out of memory
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StNoMem, 32'h0000_0000},
    // address extremes go onto the free list unchecked
    '{RowItem,  OpFree,  RegRegionStart, 32'hFFFF_FFFF, 1'b1, StOk,    32'h0000_0000},
    '{RowItem,  OpFree,  RegRegionStart, 32'h0000_0000, 1'b1, StOk,    32'h0000_0000},
    // free list serves allocs although the bump region is exhausted, oldest first
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StOk,    32'hFFFF_FFFF},
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StOk,    32'h0000_0000},
    // page address is ignored on alloc
    '{RowItem,  OpAlloc, RegRegionStart, 32'hFFFF_FFFF, 1'b1, StNoMem, 32'h0000_0000},
    // room for exactly two pages above the header
    '{RowWrite, OpAlloc, RegRegionEnd,   32'h0000_2014, 1'b0, StOk,    32'h0000_0000},
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StOk,    32'h0000_0014},
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StOk,    32'h0000_1014},
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StNoMem, 32'h0000_0000},
    // unaligned page comes back as given
    '{RowItem,  OpFree,  RegRegionStart, 32'h1234_5679, 1'b1, StOk,    32'h0000_0000},
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StOk,    32'h1234_5679},
    '{RowItem,  OpFree,  RegRegionStart, 32'hAAAA_5555, 1'b1, StOk,    32'h0000_0000},
    // start write empties the list, bump pointer wraps to 0x13
    '{RowWrite, OpAlloc, RegRegionStart, 32'hFFFF_FFFF, 1'b0, StOk,    32'h0000_0000},
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StOk,    32'h0000_0013},
    // limit test must not wrap past the top of the address space
    '{RowWrite, OpAlloc, RegRegionStart, 32'hFFFF_F000, 1'b0, StOk,    32'h0000_0000},
    '{RowWrite, OpAlloc, RegRegionEnd,   32'hFFFF_FFFF, 1'b0, StOk,    32'h0000_0000},
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StNoMem, 32'h0000_0000},
    // last page that still fits below the top
    '{RowWrite, OpAlloc, RegRegionStart, 32'hFFFF_E000, 1'b0, StOk,    32'h0000_0000},
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StOk,    32'hFFFF_E014},
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b1, StNoMem, 32'h0000_0000},
    '{RowItem,  OpFree,  RegRegionStart, 32'h5555_AAAA, 1'b0, StOk,    32'h0000_0000},
    '{RowItem,  OpAlloc, RegRegionStart, 32'h0000_0000, 1'b0, StOk,    32'h0000_0000}
  };

  page_frame_allocator_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .page_address_i    (page_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // gap length for either side: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result of one request on the in-bench allocator state, which it advances
  function automatic void predict_grant(input logic op, input logic [AddrW-1:0] addr,
                                        output status_e st, output logic [AddrW-1:0] page);
    st   = StOk;
    page = '0;
    if (op == OpAlloc) begin
      if (free_cnt != '0) begin
        // oldest freed page wins, even with the bump region exhausted
        page     = recycled[rd_idx];
        rd_idx   = rd_idx + 1'b1;
        free_cnt = free_cnt - 1'b1;
      end else if ({1'b0, next_page} + PageInc > {1'b0, cfg_end}) begin
        // compared on 33 bits so a page never wraps past the top
        st = StNoMem;
      end else begin
        page      = next_page;
        next_page = next_page + PageBytes;
      end
    end else if (free_cnt == CountFull) begin
      st = StFull;
    end else begin
      recycled[wr_idx] = addr;
      wr_idx           = wr_idx + 1'b1;
      free_cnt         = free_cnt + 1'b1;
    end
  endfunction

  // hold the request channel idle until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write followed by a readback; only called with the block idle
  task automatic write_region(input logic sel, input logic [31:0] value);
    logic [31:0] rd;
    drain_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({sel, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // register takes the value at this edge
    if (sel == RegRegionStart) begin
      cfg_start = value;
      next_page = value + HeaderOffs;
      rd_idx    = '0;
      wr_idx    = '0;
      free_cnt  = '0;
    end else begin
      cfg_end = value;
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== value) begin
      errors++;
      $display("%0t: readback of register %0d: expected %h, got %h", $time, sel, value, rd);
    end
  endtask

  // present one item, wait for its accept edge, then queue what it must return
  task automatic issue_request(input logic op, input logic [AddrW-1:0] addr,
                               input logic use_fixed, input grant_t fixed_grant);
    int unsigned gap;
    grant_t      g;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    page_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    predict_grant(op, addr, g.st, g.page);
    if (use_fixed) g = fixed_grant;
    pending_grants.push_back(g);
    if (op == OpAlloc && g.st == StOk) handed_out.push_back(g.page);
    if (op == OpFree && g.st == StFull) full_hits++;
  endtask

  // random item: frees mostly return pages handed out earlier, else any address
  task automatic issue_random(input int unsigned free_pct);
    logic             op;
    logic [AddrW-1:0] addr;
    int unsigned      pick;
    issued++;
    if (issued % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
    // now and then let the pipe run dry before the next item
    if ($urandom_range(0, 79) == 0) drain_results();
    op   = ($urandom_range(0, 99) < free_pct) ? OpFree : OpAlloc;
    addr = $urandom;
    if (op == OpFree && handed_out.size() != 0 && $urandom_range(0, 9) < 6) begin
      pick = $urandom_range(0, handed_out.size() - 1);
      addr = handed_out[pick];
      handed_out.delete(pick);
    end
    issue_request(op, addr, 1'b0, grant_t'{StOk, '0});
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned free_pct);
    repeat (n) issue_random(free_pct);
  endtask

  // result side: random stalls, none while quiet
  initial begin
    int unsigned hold;
    hold        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet) hold = pick_gap();
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    grant_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d, address %h",
                 $time, status_o, granted_address_o);
      end else begin
        e = pending_grants.pop_front();
        if (status_o !== e.st) begin
          errors++;
          $display("%0t: status: expected %0d, got %0d", $time, e.st, status_o);
        end
        if (granted_address_o !== e.page) begin
          errors++;
          $display("%0t: granted address: expected %h, got %h",
                   $time, e.page, granted_address_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("** page_frame_allocator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [AddrW-1:0] base;
    errors         = 0;
    full_hits      = 0;
    issued         = 0;
    cycles         = 0;
    quiet          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = OpAlloc;
    page_address_i = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    // state after reset
    cfg_start      = '0;
    cfg_end        = '0;
    next_page      = HeaderOffs;
    rd_idx         = '0;
    wr_idx         = '0;
    free_cnt       = '0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowWrite)
        write_region(dir_rows[i].sel, dir_rows[i].data);
      else
        issue_request(dir_rows[i].op, dir_rows[i].data, dir_rows[i].fixed,
                      grant_t'{dir_rows[i].st, dir_rows[i].page});
    end

    // small region with eight pages: out of memory comes often
    write_region(RegRegionStart, 32'h0010_0000);
    write_region(RegRegionEnd, 32'h0010_0014 + 8 * PageBytes);
    run_phase(20, 45);

    // random base and span
    base = $urandom;
    write_region(RegRegionStart, base);
    write_region(RegRegionEnd, base + HeaderOffs + $urandom_range(0, 40) * PageBytes);
    run_phase(16, 40);

    // bump region dead from the start, only recycled pages come out
    write_region(RegRegionStart, 32'hFFFF_FFFF);
    write_region(RegRegionEnd, 32'h0000_0000);
    run_phase(10, 50);

    // both limits random
    write_region(RegRegionStart, $urandom);
    write_region(RegRegionEnd, $urandom);
    run_phase(14, 50);

    // whole address space; free until the list overflows several times
    write_region(RegRegionStart, 32'h0000_0000);
    write_region(RegRegionEnd, 32'hFFFF_FFFF);
    full_hits = 0;
    while (!(free_cnt == CountFull && full_hits >= 6)) issue_random(99);

    // pop from the full list mostly by allocs, no register change
    run_phase(24, 10);

    // tighten the limit only; the list keeps its contents
    write_region(RegRegionEnd, 32'h0000_8000);
    run_phase(12, 50);

    drain_results();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("** page_frame_allocator_core: PASSED **");
    end else begin
      $display("** page_frame_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/pfa_pkg.sv
rtl/core/pfa_ctrl.sv
rtl/core/pfa_datapath.sv
rtl/core/page_frame_allocator_core.sv
test/tb_top.sv
